### hdl/mctw_pkg.sv
// shared types, widths and constants of the multi-channel task watchdog
`default_nettype none

package mctw_pkg;

	// field widths
	localparam int KIND_W    = 2;
	localparam int CHAN_W    = 3;
	localparam int SEC_W     = 16;
	localparam int TICK_W    = 6;
	localparam int DAY_W     = 17;
	localparam int CAUSE_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 17;

	// default channel count
	localparam int NUM_CHANNELS_DEF = 7;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_KICK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELOAD = 2'd2;

	// reset causes
	localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
	localparam logic [CAUSE_W-1:0] CAUSE_WDG   = 2'd1;
	localparam logic [CAUSE_W-1:0] CAUSE_DAILY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICK_SECONDS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_PERIOD     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAY_TICKS       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TIMEOUT = 2'd3;

	// register reset values
	localparam logic [TICK_W-1:0] TICK_SECONDS_RST    = 6'd5;
	localparam logic [SEC_W-1:0]  POLL_PERIOD_RST     = 16'd300;
	localparam logic [DAY_W-1:0]  DAY_TICKS_RST       = 17'd17280;
	localparam logic [SEC_W-1:0]  INITIAL_TIMEOUT_RST = 16'd15;

	// controller to datapath commands
	typedef struct packed {
		logic kick;
		logic reload;
		logic walk_start;
		logic walk_step;
		logic tick_end;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic latched;
		logic walk_last;
	} status_t;

endpackage

`default_nettype wire

### hdl/mctw_item_if.sv
// input item channel: valid, ready and the item fields
`default_nettype none

interface mctw_item_if;
	import mctw_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAN_W-1:0] channel;
	logic [SEC_W-1:0]  timeout;

	modport source (output valid, output kind, output channel, output timeout, input ready);
	modport sink (input valid, input kind, input channel, input timeout, output ready);
endinterface

`default_nettype wire

### hdl/mctw_result_if.sv
// result channel: valid, ready and the result fields
`default_nettype none

interface mctw_result_if;
	import mctw_pkg::*;

	logic               valid;
	logic               ready;
	logic               system_reset;
	logic [CAUSE_W-1:0] reset_cause;
	logic [CHAN_W-1:0]  expired_channel;
	logic [SEC_W-1:0]   time_to_poll;

	modport source (output valid, output system_reset, output reset_cause,
		output expired_channel, output time_to_poll, input ready);
	modport sink (input valid, input system_reset, input reset_cause,
		input expired_channel, input time_to_poll, output ready);
endinterface

`default_nettype wire

### hdl/mctw_cfg_if.sv
// configuration write channel: valid, ready, register index and data
`default_nettype none

interface mctw_cfg_if;
	import mctw_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/mctw_ctrl.sv
// controller state machine: sequences one item and hands out the result beat
`default_nettype none

module mctw_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [mctw_pkg::KIND_W-1:0] in_kind,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	input  wire mctw_pkg::status_t         status,
	output mctw_pkg::cmd_t                 cmd
);
	import mctw_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_TICK_END,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.kick       = accept && !status.latched && (in_kind == KIND_KICK);
		cmd.reload     = accept && !status.latched && (in_kind == KIND_RELOAD);
		cmd.walk_start = accept && !status.latched && (in_kind == KIND_TICK);
		cmd.walk_step  = (state_q == ST_WALK);
		cmd.tick_end   = (state_q == ST_TICK_END);
		cmd.emit       = (state_q == ST_EMIT) && slot_free;
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.walk_start) begin
						state_q <= ST_WALK;
					end else if (accept) begin
						state_q <= ST_EMIT;
					end
				end
				ST_WALK: begin
					if (status.walk_last) begin
						state_q <= ST_TICK_END;
					end
				end
				ST_TICK_END: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/mctw_datapath.sv
// datapath: channel timers, countdowns, reset latch, registers and result
`default_nettype none

module mctw_datapath #(
	parameter int NUM_CHANNELS = mctw_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mctw_pkg::cmd_t                cmd,
	output mctw_pkg::status_t                  status,
	input  wire logic [mctw_pkg::CHAN_W-1:0]   in_channel,
	input  wire logic [mctw_pkg::SEC_W-1:0]    in_timeout,
	input  wire logic                          cfg_we,
	input  wire logic [mctw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mctw_pkg::CFG_DAT_W-1:0] cfg_data,
	output logic                               system_reset,
	output logic [mctw_pkg::CAUSE_W-1:0]       reset_cause,
	output logic [mctw_pkg::CHAN_W-1:0]        expired_channel,
	output logic [mctw_pkg::SEC_W-1:0]         time_to_poll
);
	import mctw_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// configuration registers
	logic [TICK_W-1:0] tick_seconds_q;
	logic [SEC_W-1:0]  poll_period_q;

	// watchdog state
	logic [SEC_W-1:0]   timers_q [NUM_CHANNELS];
	logic [SEC_W-1:0]   poll_q;
	logic [DAY_W-1:0]   day_q;
	logic               latched_q;
	logic [CAUSE_W-1:0] cause_q;
	logic [IDX_W-1:0]   latched_idx_q;

	// walk state
	logic [IDX_W-1:0]  idx_q;
	logic              found_q;
	logic [IDX_W-1:0]  hit_q;

	// result register
	logic               res_reset_q;
	logic [CAUSE_W-1:0] res_cause_q;
	logic [CHAN_W-1:0]  res_chan_q;
	logic [SEC_W-1:0]   res_poll_q;

	logic [SEC_W-1:0] step;
	logic [SEC_W-1:0] cur_timer;
	logic [SEC_W-1:0] next_timer;
	logic             kick_ok;
	logic [IDX_W-1:0] kick_idx;
	logic             day_hit;

	assign step       = SEC_W'(tick_seconds_q);
	assign cur_timer  = timers_q[idx_q];
	assign next_timer = (cur_timer > step) ? (cur_timer - step) : '0;
	assign kick_ok    = (int'(in_channel) < NUM_CHANNELS);
	assign kick_idx   = IDX_W'(in_channel);
	assign day_hit    = (day_q <= DAY_W'(1));

	assign status.latched   = latched_q;
	assign status.walk_last = (idx_q == IDX_W'(NUM_CHANNELS - 1));

	assign system_reset    = res_reset_q;
	assign reset_cause     = res_cause_q;
	assign expired_channel = res_chan_q;
	assign time_to_poll    = res_poll_q;

	// configuration writes; initial timeout and day count only bear on reset, so they are not kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_seconds_q <= TICK_SECONDS_RST;
			poll_period_q  <= POLL_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_SECONDS:    tick_seconds_q <= cfg_data[TICK_W-1:0];
				REG_POLL_PERIOD:     poll_period_q  <= cfg_data[SEC_W-1:0];
				REG_DAY_TICKS:       ;
				REG_INITIAL_TIMEOUT: ;
				default: ;
			endcase
		end
	end

	// channel timers: kick load or walk update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				timers_q[i] <= INITIAL_TIMEOUT_RST;
			end
		end else if (cmd.kick && kick_ok) begin
			timers_q[kick_idx] <= in_timeout;
		end else if (cmd.walk_step) begin
			timers_q[idx_q] <= next_timer;
		end
	end

	// walk index and first expired channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			hit_q   <= '0;
		end else if (cmd.walk_start) begin
			idx_q   <= '0;
			found_q <= 1'b0;
			hit_q   <= '0;
		end else if (cmd.walk_step) begin
			idx_q <= idx_q + IDX_W'(1);
			if ((next_timer == '0) && !found_q) begin
				found_q <= 1'b1;
				hit_q   <= idx_q;
			end
		end
	end

	// poll countdown, day countdown and reset latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_q        <= POLL_PERIOD_RST;
			day_q         <= DAY_TICKS_RST;
			latched_q     <= 1'b0;
			cause_q       <= CAUSE_NONE;
			latched_idx_q <= '0;
		end else if (cmd.reload) begin
			poll_q <= poll_period_q;
		end else if (cmd.tick_end) begin
			if (poll_q > step) begin
				poll_q <= poll_q - step;
			end
			day_q <= day_hit ? '0 : (day_q - DAY_W'(1));
			if (found_q) begin
				latched_q     <= 1'b1;
				cause_q       <= CAUSE_WDG;
				latched_idx_q <= hit_q;
			end else if (day_hit) begin
				latched_q     <= 1'b1;
				cause_q       <= CAUSE_DAILY;
				latched_idx_q <= '0;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_reset_q <= latched_q;
			res_cause_q <= cause_q;
			res_chan_q  <= (cause_q == CAUSE_WDG) ? CHAN_W'(latched_idx_q) : '0;
			res_poll_q  <= poll_q;
		end
	end

endmodule

`default_nettype wire

### hdl/multi_channel_task_watchdog_core.sv
// Multi-channel task watchdog core, top level.
//
// Channels: item (sink) takes tick, kick and reload beats; result (source)
// gives one beat per item with the reset latch, its cause, the expired
// channel and the poll countdown; cfg (sink) is always ready and writes
// tick_seconds and poll_period (day_ticks and initial_timeout are ignored).
// A kick, a reload, an unused kind or any item after a reset has latched
// goes from acceptance straight to the emit state. A tick walks the channel
// timers one per cycle through a single subtract unit, then passes the
// tick-end state before the emit state. One item is in work at a time; the
// next is accepted once the current result sits in the output register.
// A stalled result receiver holds that register; the core then waits before
// handing over the following result and accepts nothing more.
// Reset puts every channel at 15 seconds, the poll countdown at the poll
// period reset value, the day countdown at the day_ticks reset value and
// clears the reset latch; no result is pending afterwards.
`default_nettype none

module multi_channel_task_watchdog_core #(
	parameter int NUM_CHANNELS = mctw_pkg::NUM_CHANNELS_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	mctw_item_if.sink     item,
	mctw_result_if.source result,
	mctw_cfg_if.sink      cfg
);
	import mctw_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg.ready = 1'b1;

	// sequencing
	mctw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_kind   (item.kind),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// state and arithmetic
	mctw_datapath #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_channel      (item.channel),
		.in_timeout      (item.timeout),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.system_reset    (result.system_reset),
		.reset_cause     (result.reset_cause),
		.expired_channel (result.expired_channel),
		.time_to_poll    (result.time_to_poll)
	);

endmodule

`default_nettype wire

### tb/sv/multi_channel_task_watchdog_core_test.sv
// testbench of the multi-channel task watchdog core: directed and random beats against a predictor
`timescale 1ns / 100ps

module multi_channel_task_watchdog_core_test;
	import mctw_pkg::*;

	localparam int NCH          = NUM_CHANNELS_DEF;
	localparam int IDLE_PCT     = 21;
	localparam int BODY_BEATS   = 1650;
	localparam int PHASE_BEATS  = 150;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 20;
	localparam int CALM_FROM    = 500;
	localparam int CALM_TO      = 800;
	localparam int AFTER_LATCH  = 30;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// ways the run ends, since a latched reset stays until the next hardware reset
	typedef enum int {END_EXPIRY, END_ZERO_KICK} ending_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAN_W-1:0] chan;
		logic [SEC_W-1:0]  tmo;
	} beat_t;

	typedef struct packed {
		logic               sys_rst;
		logic [CAUSE_W-1:0] cause;
		logic [CHAN_W-1:0]  chan;
		logic [SEC_W-1:0]   poll;
	} wd_status_t;

	typedef struct packed {
		logic [NCH-1:0][SEC_W-1:0] timers;
		logic [SEC_W-1:0]          poll;
		logic [DAY_W-1:0]          day;
		logic                      latched;
		logic [CAUSE_W-1:0]        cause;
		logic [CHAN_W-1:0]         chan;
		logic [TICK_W-1:0]         tick_len;
		logic [SEC_W-1:0]          poll_period;
		logic [DAY_W-1:0]          day_ticks;
		logic [SEC_W-1:0]          init_timeout;
	} wd_state_t;

	logic clk;
	logic arst_n;

	mctw_item_if   item_ch();
	mctw_result_if result_ch();
	mctw_cfg_if    cfg_ch();

	beat_t      beats_to_send[$];
	wd_status_t status_due[$];
	wd_state_t  wd_now;
	wd_state_t  wd_plan;
	int         n_queued;
	int         n_sent;
	int         n_seen;
	int         n_fail;
	int         quiet;
	int         hold_left;
	bit         held;

	multi_channel_task_watchdog_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// state right after a hardware reset
	function automatic wd_state_t watchdog_after_reset();
		wd_state_t s;
		int i;
		s = '0;
		for (i = 0; i < NCH; i++)
			s.timers[i] = INITIAL_TIMEOUT_RST;
		s.poll         = POLL_PERIOD_RST;
		s.day          = DAY_TICKS_RST;
		s.tick_len     = TICK_SECONDS_RST;
		s.poll_period  = POLL_PERIOD_RST;
		s.day_ticks    = DAY_TICKS_RST;
		s.init_timeout = INITIAL_TIMEOUT_RST;
		return s;
	endfunction

	// register write, masked to the register width
	function automatic wd_state_t store_reg(wd_state_t s, logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DAT_W-1:0] d);
		case (idx)
			REG_TICK_SECONDS:    s.tick_len = d[TICK_W-1:0];
			REG_POLL_PERIOD:     s.poll_period = d[SEC_W-1:0];
			REG_DAY_TICKS:       s.day_ticks = d[DAY_W-1:0];
			REG_INITIAL_TIMEOUT: s.init_timeout = d[SEC_W-1:0];
			default: ;
		endcase
		return s;
	endfunction

	// watchdog state after one item
	function automatic wd_state_t advance_watchdog(wd_state_t s, beat_t b);
		wd_state_t n;
		logic [SEC_W-1:0] step;
		logic hit;
		logic day_hit;
		logic [CHAN_W-1:0] hit_idx;
		int i;
		n = s;
		step = SEC_W'(s.tick_len);
		hit = 1'b0;
		day_hit = 1'b0;
		hit_idx = '0;
		if (!s.latched) begin
			case (b.kind)
				KIND_TICK: begin
					// saturating walk, first channel at zero wins
					for (i = 0; i < NCH; i++) begin
						n.timers[i] = (s.timers[i] > step) ? s.timers[i] - step : '0;
						if (n.timers[i] == '0 && !hit) begin
							hit = 1'b1;
							hit_idx = CHAN_W'(i);
						end
					end
					if (s.poll > step)
						n.poll = s.poll - step;
					if (s.day <= DAY_W'(1)) begin
						n.day = '0;
						day_hit = 1'b1;
					end else begin
						n.day = s.day - DAY_W'(1);
					end
					// expiry wins over the daily reset on the same tick
					if (hit) begin
						n.latched = 1'b1;
						n.cause = CAUSE_WDG;
						n.chan = hit_idx;
					end else if (day_hit) begin
						n.latched = 1'b1;
						n.cause = CAUSE_DAILY;
						n.chan = '0;
					end
				end
				KIND_KICK: begin
					if (int'(b.chan) < NCH)
						n.timers[b.chan] = b.tmo;
				end
				KIND_RELOAD: n.poll = s.poll_period;
				default: ;
			endcase
		end
		return n;
	endfunction

	function automatic wd_status_t watchdog_status(wd_state_t s);
		wd_status_t r;
		r.sys_rst = s.latched;
		r.cause = s.cause;
		r.chan = (s.cause == CAUSE_WDG) ? s.chan : '0;
		r.poll = s.poll;
		return r;
	endfunction

	function automatic logic [SEC_W-1:0] pick_timeout();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return SEC_W'($urandom_range(1, 200));
			default: return SEC_W'($urandom());
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		n_fail++;
		$display("mismatch on %s at result %0d: got %0h, want %0h", what, n_seen, got, want);
	endtask

	task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [CHAN_W-1:0] chan,
		input logic [SEC_W-1:0] tmo);
		beat_t b;
		b.kind = kind;
		b.chan = chan;
		b.tmo = tmo;
		beats_to_send.push_back(b);
		wd_plan = advance_watchdog(wd_plan, b);
		n_queued++;
	endtask

	// kick every channel that the next tick would expire
	task automatic rescue_channels(input logic [SEC_W-1:0] top);
		logic [SEC_W-1:0] step;
		int i;
		step = SEC_W'(wd_plan.tick_len);
		for (i = 0; i < NCH; i++)
			if (wd_plan.timers[i] <= step)
				queue_item(KIND_KICK, CHAN_W'(i),
					SEC_W'($urandom_range(int'(step) + 1, int'(top))));
	endtask

	task automatic queue_tick(input bit rescue, input logic [SEC_W-1:0] top);
		if (rescue)
			rescue_channels(top);
		queue_item(KIND_TICK, CHAN_W'($urandom_range(0, 7)), SEC_W'($urandom()));
	endtask

	task automatic queue_random_item(input logic [SEC_W-1:0] top);
		int r;
		r = $urandom_range(0, 99);
		if (r < 38)
			queue_tick(1'b1, top);
		else if (r < 80)
			queue_item(KIND_KICK, CHAN_W'($urandom_range(0, 7)), pick_timeout());
		else if (r < 92)
			queue_item(KIND_RELOAD, CHAN_W'($urandom_range(0, 7)), SEC_W'($urandom()));
		else
			queue_item(KIND_UNUSED, CHAN_W'($urandom_range(0, 7)), SEC_W'($urandom()));
	endtask

	// wait until every queued beat has its result back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (n_seen != n_queued);
	endtask

	// one register write; valid stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		wd_now = store_reg(wd_now, idx, d);
	endtask

	task automatic configure(input logic [TICK_W-1:0] ts, input logic [SEC_W-1:0] pp,
		input logic [DAY_W-1:0] dt, input logic [SEC_W-1:0] it, input bit junk);
		logic [CFG_DAT_W-1:0] d;
		logic [31:0] r;
		wait_drained();
		r = $urandom();
		// unused upper data bits set at random when junk is asked for
		d = CFG_DAT_W'(ts);
		if (junk)
			d[CFG_DAT_W-1:TICK_W] = r[CFG_DAT_W-TICK_W-1:0];
		write_reg(REG_TICK_SECONDS, d);
		d = CFG_DAT_W'(pp);
		if (junk)
			d[SEC_W] = r[20];
		write_reg(REG_POLL_PERIOD, d);
		write_reg(REG_DAY_TICKS, dt);
		d = CFG_DAT_W'(it);
		if (junk)
			d[SEC_W] = r[21];
		write_reg(REG_INITIAL_TIMEOUT, d);
		cfg_ch.valid <= 1'b0;
		wd_plan = wd_now;
	endtask

	// item driver: next beat from the queue once the current one is taken
	always @(posedge clk) begin : drive_items
		beat_t taken;
		beat_t nb;
		bit rest;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				taken = {item_ch.kind, item_ch.channel, item_ch.timeout};
				wd_now = advance_watchdog(wd_now, taken);
				status_due.push_back(watchdog_status(wd_now));
				n_sent++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				rest = (n_sent < CALM_FROM || n_sent >= CALM_TO) &&
					($urandom_range(0, 99) < IDLE_PCT);
				if (beats_to_send.size() != 0 && !rest) begin
					nb = beats_to_send.pop_front();
					item_ch.kind <= nb.kind;
					item_ch.channel <= nb.chan;
					item_ch.timeout <= nb.tmo;
					item_ch.valid <= 1'b1;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin : watch_results
		wd_status_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (status_due.size() == 0) begin
					flag_mismatch("result with no item pending", 0, 0);
				end else begin
					want = status_due.pop_front();
					if (result_ch.system_reset !== want.sys_rst)
						flag_mismatch("system_reset", int'(result_ch.system_reset),
							int'(want.sys_rst));
					if (result_ch.reset_cause !== want.cause)
						flag_mismatch("reset_cause", int'(result_ch.reset_cause),
							int'(want.cause));
					if (result_ch.expired_channel !== want.chan)
						flag_mismatch("expired_channel", int'(result_ch.expired_channel),
							int'(want.chan));
					if (result_ch.time_to_poll !== want.poll)
						flag_mismatch("time_to_poll", int'(result_ch.time_to_poll),
							int'(want.poll));
					n_seen++;
				end
			end
			// one long hold-off so the core fills up, otherwise random stalls
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (!held && n_seen >= 100) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= (n_seen >= CALM_FROM && n_seen < CALM_TO) ||
					($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// stall watchdog: too long with no beat on any channel
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		ending_t ending;
		int phase;
		int target;
		int c;
		int i;
		int r;
		logic [SEC_W-1:0] step;
		logic [SEC_W-1:0] v;
		logic [TICK_W-1:0] ts;
		logic [SEC_W-1:0] pp;
		logic [DAY_W-1:0] dt;
		logic [SEC_W-1:0] it;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_TICK;
		item_ch.channel = '0;
		item_ch.timeout = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TICK_SECONDS;
		cfg_ch.data = '0;
		n_queued = 0;
		n_sent = 0;
		n_seen = 0;
		n_fail = 0;
		quiet = 0;
		hold_left = 0;
		held = 1'b0;
		wd_now = watchdog_after_reset();
		wd_plan = wd_now;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed beats under reset settings
		queue_item(KIND_UNUSED, 3'd7, 16'hFFFF);
		queue_item(KIND_KICK, 3'd7, 16'h0000);
		queue_tick(1'b1, 16'hFFFF);
		queue_item(KIND_RELOAD, 3'd0, 16'h0000);
		queue_item(KIND_KICK, 3'd0, 16'hFFFF);
		queue_item(KIND_KICK, 3'd1, 16'hAAAA);
		queue_item(KIND_KICK, 3'd2, 16'h5555);
		queue_item(KIND_KICK, 3'd3, 16'd6);
		queue_item(KIND_KICK, 3'd4, 16'h0000);
		queue_item(KIND_KICK, 3'd4, 16'd100);
		queue_item(KIND_KICK, 3'd5, 16'h8000);
		queue_tick(1'b1, 16'hFFFF);
		queue_item(KIND_KICK, 3'd3, 16'd7);
		queue_item(KIND_KICK, 3'd6, 16'h7FFF);
		queue_tick(1'b1, 16'hFFFF);
		queue_item(KIND_RELOAD, 3'd7, 16'hFFFF);
		queue_item(KIND_UNUSED, 3'd0, 16'h0000);
		queue_tick(1'b1, 16'hFFFF);

		// random body in phases, each with its own register settings
		for (phase = 0; n_queued < BODY_BEATS; phase++) begin
			case (phase)
				0: begin ts = 6'd1;  pp = 16'd0;     dt = 17'd1;      it = 16'd0;     end
				1: begin ts = 6'd60; pp = 16'hFFFF;  dt = 17'h1FFFF;  it = 16'hFFFF;  end
				2: begin ts = 6'd63; pp = 16'd1;     dt = 17'd0;      it = SEC_W'($urandom()); end
				3: begin
					ts = 6'd0;
					pp = SEC_W'($urandom_range(0, 100));
					dt = DAY_W'($urandom_range(1, 131071));
					it = SEC_W'($urandom());
				end
				default: begin
					ts = TICK_W'($urandom_range(1, 60));
					pp = ($urandom_range(0, 1) != 0) ? SEC_W'($urandom_range(0, 120)) :
						SEC_W'($urandom());
					dt = DAY_W'($urandom_range(1, 131071));
					it = SEC_W'($urandom());
				end
			endcase
			configure(ts, pp, dt, it, phase >= 2 && $urandom_range(0, 1) != 0);
			target = n_queued + PHASE_BEATS;
			while (n_queued < target)
				queue_random_item(($urandom_range(0, 1) != 0) ? 16'd300 : 16'hFFFF);
		end

		// ending: one latched reset, then beats that must be ignored
		ending = ending_t'($urandom_range(0, 1));
		ts = TICK_W'($urandom_range(1, 60));
		if (ending == END_ZERO_KICK && $urandom_range(0, 1) != 0)
			ts = '0;
		configure(ts, SEC_W'($urandom()), DAY_W'($urandom_range(1, 131071)),
			SEC_W'($urandom()), 1'b0);
		step = SEC_W'(wd_plan.tick_len);
		c = $urandom_range(0, NCH - 1);
		case (ending)
			END_EXPIRY: begin
				// equal small timeouts so the lowest index has to win
				v = SEC_W'($urandom_range(1, 3 * int'(step)));
				queue_item(KIND_KICK, CHAN_W'(c), v);
				for (i = 0; i < NCH; i++)
					if (i != c && $urandom_range(0, 2) == 0)
						queue_item(KIND_KICK, CHAN_W'(i), v);
				while (!wd_plan.latched) begin
					r = $urandom_range(0, 99);
					if (r < 75)
						queue_tick(1'b0, '0);
					else if (r < 90)
						queue_item(KIND_RELOAD, CHAN_W'($urandom_range(0, 7)), SEC_W'($urandom()));
					else
						queue_item(KIND_UNUSED, CHAN_W'($urandom_range(0, 7)), SEC_W'($urandom()));
				end
			end
			END_ZERO_KICK: begin
				// a channel already at zero expires even with a zero tick length
				queue_item(KIND_KICK, CHAN_W'(c), '0);
				if (c < NCH - 1 && $urandom_range(0, 1) != 0)
					queue_item(KIND_KICK, CHAN_W'($urandom_range(c + 1, NCH - 1)), '0);
				queue_tick(1'b0, '0);
			end
			default: ;
		endcase
		repeat (AFTER_LATCH)
			queue_item(KIND_W'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 7)),
				SEC_W'($urandom()));

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
hdl/mctw_pkg.sv
hdl/mctw_item_if.sv
hdl/mctw_result_if.sv
hdl/mctw_cfg_if.sv
hdl/mctw_ctrl.sv
hdl/mctw_datapath.sv
hdl/multi_channel_task_watchdog_core.sv
tb/sv/multi_channel_task_watchdog_core_test.sv
